[src/ts_pkg.sv]
`default_nettype none

package ts_pkg;

    // Number of series terms; one cell in the chain per term (legal range 1 to 10).
    localparam int NUM_TERMS = 10;
    localparam int MAX_TERMS = 10;

    // Field widths of the datapath.
    localparam int ANGLE_W   = 32;
    localparam int RESULT_W  = 32;
    localparam int ABS_W     = 32;
    localparam int X2_W      = 33;
    localparam int MAG_W     = 52;
    localparam int F_W       = 30;
    localparam int ACC_W     = 56;
    localparam int IDX_W     = $clog2(MAX_TERMS + 1);

    // Fixed-point shifts.
    localparam int X2_SHIFT    = 30;
    localparam int MAG0_SHIFT  = 12;
    localparam int RECIP_SHIFT = 32;
    localparam int FRAC_SPLIT  = 26;
    localparam int OUT_SHIFT   = 10;

    // One beat as it travels down the term chain.
    typedef struct packed {
        logic                    neg;
        logic [X2_W-1:0]         x2;
        logic [MAG_W-1:0]        mag;
        logic [F_W-1:0]          f;
        logic signed [ACC_W-1:0] acc;
        logic [IDX_W-1:0]        idx;
    } ts_beat_t;

    // Rounded Q0.32 reciprocals of (2k+2)(2k+3); zero past the last term.
    function automatic logic [F_W-1:0] recip(input logic [IDX_W-1:0] idx);
        logic [F_W-1:0] r;
        case (idx)
            4'd0:    r = F_W'(715827883);
            4'd1:    r = F_W'(214748365);
            4'd2:    r = F_W'(102261126);
            4'd3:    r = F_W'(59652324);
            4'd4:    r = F_W'(39045157);
            4'd5:    r = F_W'(27531842);
            4'd6:    r = F_W'(20452225);
            4'd7:    r = F_W'(15790321);
            4'd8:    r = F_W'(12558384);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[src/ts_prep.sv]
`default_nettype none

module ts_prep (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [ts_pkg::ANGLE_W-1:0] in_angle,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output ts_pkg::ts_beat_t              out_beat
);
    import ts_pkg::*;

    localparam int SQ_W = 2 * ABS_W;
    localparam int FP_W = X2_W + F_W;

    logic              v1_reg, v2_reg, v3_reg;
    logic              rdy1, rdy2, rdy3;
    logic              neg1_reg, neg2_reg;
    logic [ABS_W-1:0]  a1_reg;
    logic [X2_W-1:0]   x2_reg;
    logic [MAG_W-1:0]  mag0_reg;
    ts_beat_t          beat_reg;

    logic [ABS_W-1:0]  a_next;
    logic [SQ_W-1:0]   sq;
    logic [FP_W-1:0]   fprod;

    // A stage takes a new beat when it is empty or its beat moves on.
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Magnitude of the angle; the most negative code maps to 2^31.
    assign a_next = in_angle[ANGLE_W-1] ? ABS_W'(~in_angle + 1'b1) : ABS_W'(in_angle);

    // Square of the magnitude and the first reduction factor.
    assign sq    = SQ_W'(a1_reg) * SQ_W'(a1_reg);
    assign fprod = FP_W'(x2_reg) * FP_W'(recip('0));

    // Valid bits of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload of the three stages.
    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            a1_reg   <= a_next;
            neg1_reg <= in_angle[ANGLE_W-1];
        end
        if (rdy2 && v1_reg) begin
            x2_reg   <= sq[X2_SHIFT+X2_W-1:X2_SHIFT];
            mag0_reg <= MAG_W'(a1_reg) << MAG0_SHIFT;
            neg2_reg <= neg1_reg;
        end
        if (rdy3 && v2_reg) begin
            beat_reg.neg <= neg2_reg;
            beat_reg.x2  <= x2_reg;
            beat_reg.mag <= mag0_reg;
            beat_reg.f   <= fprod[RECIP_SHIFT+F_W-1:RECIP_SHIFT];
            beat_reg.acc <= '0;
            beat_reg.idx <= '0;
        end
    end

    assign out_valid = v3_reg;
    assign out_beat  = beat_reg;

endmodule

`default_nettype wire

[src/ts_cell.sv]
`default_nettype none

module ts_cell (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  ts_pkg::ts_beat_t in_beat,
    output logic             out_valid,
    input  wire logic        out_ready,
    output ts_pkg::ts_beat_t out_beat
);
    import ts_pkg::*;

    localparam int HI_W   = MAG_W - FRAC_SPLIT;
    localparam int PHI_W  = HI_W + F_W;
    localparam int PLO_W  = FRAC_SPLIT + F_W;
    localparam int FP_W   = X2_W + F_W;

    logic                    valid_reg;
    ts_beat_t                beat_reg;
    ts_beat_t                beat_next;

    logic [PHI_W-1:0]        prod_hi;
    logic [PLO_W-1:0]        prod_lo;
    logic [FP_W-1:0]         fprod;
    logic [IDX_W-1:0]        idx_inc;
    logic signed [ACC_W-1:0] term_s;

    assign in_ready = !valid_reg || out_ready;
    assign idx_inc  = in_beat.idx + 1'b1;

    // Next term magnitude: term * f / 2^26, split so that nothing is lost.
    assign prod_hi = PHI_W'(in_beat.mag[MAG_W-1:FRAC_SPLIT]) * PHI_W'(in_beat.f);
    assign prod_lo = PLO_W'(in_beat.mag[FRAC_SPLIT-1:0]) * PLO_W'(in_beat.f);

    // Reduction factor for the following cell.
    assign fprod = FP_W'(in_beat.x2) * FP_W'(recip(idx_inc));

    // Odd-numbered terms are subtracted.
    assign term_s = $signed(ACC_W'(in_beat.mag));

    always_comb begin
        beat_next     = in_beat;
        beat_next.mag = MAG_W'(prod_hi) + MAG_W'(prod_lo[PLO_W-1:FRAC_SPLIT]);
        beat_next.f   = fprod[RECIP_SHIFT+F_W-1:RECIP_SHIFT];
        beat_next.acc = in_beat.idx[0] ? (in_beat.acc - term_s) : (in_beat.acc + term_s);
        beat_next.idx = idx_inc;
    end

    // Valid bit of the cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload of the cell.
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

`default_nettype wire

[src/ts_out.sv]
`default_nettype none

module ts_out (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  ts_pkg::ts_beat_t                 in_beat,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ts_pkg::RESULT_W-1:0]      out_value
);
    import ts_pkg::*;

    localparam int M_W = ACC_W - OUT_SHIFT;

    logic                valid_reg;
    logic [RESULT_W-1:0] value_reg;
    logic [RESULT_W-1:0] value_next;

    logic [ACC_W-1:0]    abs_acc;
    logic [M_W-1:0]      m;
    logic                res_neg;
    logic                too_big;

    assign in_ready = !valid_reg || out_ready;

    // Truncate toward zero, apply the sign of the angle, then saturate.
    assign abs_acc = in_beat.acc[ACC_W-1] ? ACC_W'(-in_beat.acc) : ACC_W'(in_beat.acc);
    assign m       = abs_acc[ACC_W-1:OUT_SHIFT];
    assign res_neg = in_beat.acc[ACC_W-1] ^ in_beat.neg;
    assign too_big = (m[M_W-1:RESULT_W-1] != '0);

    always_comb begin
        if (!res_neg) begin
            value_next = too_big ? {1'b0, {(RESULT_W-1){1'b1}}} : m[RESULT_W-1:0];
        end else begin
            value_next = too_big ? {1'b1, {(RESULT_W-1){1'b0}}} : (~m[RESULT_W-1:0] + 1'b1);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            value_reg <= value_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_value = value_reg;

endmodule

`default_nettype wire

[src/taylor_sine.sv]
`default_nettype none

// Sine by a truncated Maclaurin series. Each beat on the s_ channel carries one
// angle in radians (signed Q3.28, meant to lie strictly inside -2pi..+2pi); each
// beat on the m_ channel returns the sum of the first NUM_TERMS series terms as a
// signed Q1.30 value, saturated at the ends of its range. Results leave in the
// order the angles arrived, one per angle. The block takes a new angle every clock
// cycle and returns one result per cycle once full, while m_ready stays high. An
// angle passes a front end that forms |x|, x^2 and the first reduction factor in
// turn, then a chain of identical cells, one per term, each with one term multiply
// and one accumulate, and last the output register, which truncates toward zero
// and saturates. Every stage has its own valid bit, so a stall on the m_ side
// holds only the stages that are full, and nothing is kept between angles.
module taylor_sine (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [ts_pkg::ANGLE_W-1:0] s_angle,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [ts_pkg::RESULT_W-1:0] m_sine_value
);
    import ts_pkg::*;

    logic                chain_valid [NUM_TERMS+1];
    logic                chain_ready [NUM_TERMS+1];
    ts_beat_t            chain_beat  [NUM_TERMS+1];
    logic [RESULT_W-1:0] result;

    // Angle magnitude, square and first reduction factor.
    ts_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_angle  (ANGLE_W'(s_angle)),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_beat  (chain_beat[0])
    );

    // One cell per series term.
    for (genvar i = 0; i < NUM_TERMS; i++) begin : g_cell
        ts_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_beat   (chain_beat[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_beat  (chain_beat[i+1])
        );
    end

    // Sign, truncation and saturation into the output register.
    ts_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[NUM_TERMS]),
        .in_ready  (chain_ready[NUM_TERMS]),
        .in_beat   (chain_beat[NUM_TERMS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_value (result)
    );

    assign m_sine_value = $signed(result);

endmodule

`default_nettype wire

[bench/tb_taylor_sine.sv]
`default_nettype none

module tb_taylor_sine;

    timeunit 1ns;
    timeprecision 1ps;

    import ts_pkg::*;

    localparam int N_RANDOM     = 1000;
    localparam int N_CALM       = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * (NUM_TERMS + 4);
    localparam int MAX_REPORTS  = 30;

    // Angle range strictly inside -2pi .. +2pi in Q3.28.
    localparam logic [31:0] ANGLE_MAX  = 32'd1686629712;
    localparam logic [31:0] ANGLE_SPAN = 32'd3373259424;

    // One directed probe; a known sine is checked as typed, otherwise predicted.
    typedef struct packed {
        logic [ANGLE_W-1:0]  angle;
        logic                known;
        logic [RESULT_W-1:0] sine;
    } probe_t;

    // One angle in flight and the sine it must produce.
    typedef struct packed {
        logic [ANGLE_W-1:0]  angle;
        logic [RESULT_W-1:0] sine;
    } sine_due_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [ANGLE_W-1:0]  s_angle;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [RESULT_W-1:0] m_sine_value;

    sine_due_t pending_sines [$];
    probe_t    probes [0:15];
    int        sine_mismatches;
    int        quiet_cycles;
    bit        pacing_on;
    int        gap_chance;

    taylor_sine u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_angle      (s_angle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sine_value (m_sine_value)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Series sum on |x| with each term derived from the previous one, sign applied last,
    // then truncation toward zero to Q1.30 with saturation.
    function automatic logic [RESULT_W-1:0] series_sine(input logic [ANGLE_W-1:0] ang);
        logic [63:0]        abs_x;
        logic [63:0]        x_sq;
        logic [63:0]        term;
        logic [63:0]        step;
        logic [63:0]        inv;
        logic [63:0]        mag_out;
        logic signed [63:0] sum;
        int                 n;
        int                 k;
        n = NUM_TERMS;
        if (n < 1) n = 1;
        if (n > MAX_TERMS) n = MAX_TERMS;
        abs_x = ang[31] ? (64'h1_0000_0000 - {32'h0, ang}) : {32'h0, ang};
        x_sq  = (abs_x * abs_x) >> 30;
        term  = abs_x << 12;
        sum   = '0;
        for (k = 0; k < n; k++) begin
            if (k % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
            if (k + 1 < n && k < MAX_TERMS - 1) begin
                // Rounded 2^32 / ((2k+2)(2k+3)).
                case (k)
                    0:       inv = 64'd715827883;
                    1:       inv = 64'd214748365;
                    2:       inv = 64'd102261126;
                    3:       inv = 64'd59652324;
                    4:       inv = 64'd39045157;
                    5:       inv = 64'd27531842;
                    6:       inv = 64'd20452225;
                    7:       inv = 64'd15790321;
                    default: inv = 64'd12558384;
                endcase
                step = (x_sq * inv) >> 32;
                term = (term >> 26) * step + (((term & 64'h3FF_FFFF) * step) >> 26);
            end
        end
        if (ang[31]) sum = -sum;
        if (sum >= 0) begin
            mag_out = sum;
            mag_out = mag_out >> 10;
            return (mag_out > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_out[31:0];
        end
        mag_out = -sum;
        mag_out = mag_out >> 10;
        if (mag_out >= 64'h8000_0000) return 32'h8000_0000;
        mag_out = 64'h1_0000_0000 - mag_out;
        return mag_out[31:0];
    endfunction

    // Present one angle from a falling edge until it is accepted, then step to the
    // next falling edge. An optional gap comes first while pacing is on.
    task automatic send_angle(input logic [ANGLE_W-1:0] ang,
                              input logic [RESULT_W-1:0] sine);
        int gap;
        if (pacing_on && $urandom_range(99, 0) < gap_chance) begin
            gap = $urandom_range(8, 1);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_angle = ang;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_sines.push_back('{angle: ang, sine: sine});
        @(negedge aclk);
    endtask

    // Result side: compare every accepted beat with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_sines.size() == 0) begin
                sine_mismatches++;
                if (sine_mismatches <= MAX_REPORTS) begin
                    $display("%0t: unexpected result beat: expected none, actual %h",
                             $time, m_sine_value);
                end
            end else begin
                if (m_sine_value !== pending_sines[0].sine) begin
                    sine_mismatches++;
                    if (sine_mismatches <= MAX_REPORTS) begin
                        $display("%0t: sine_value for angle %h: expected %h, actual %h",
                                 $time, pending_sines[0].angle, pending_sines[0].sine,
                                 m_sine_value);
                    end
                end
                void'(pending_sines.pop_front());
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver: ready stretches broken by stall bursts while pacing is on.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (pacing_on && $urandom_range(3, 0) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(8, 1) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(7, 0) == 0) begin
                    repeat ($urandom_range(60, 30) - 1) @(negedge aclk);
                end else begin
                    repeat ($urandom_range(16, 1) - 1) @(negedge aclk);
                end
            end
        end
    end

    // Stimulus: reset, directed probes, then random angles.
    initial begin
        logic [ANGLE_W-1:0] ang;
        int                 i;
        int                 pick;
        sine_mismatches = 0;
        quiet_cycles    = 0;
        pacing_on       = 1'b1;
        gap_chance      = 25;
        s_valid         = 1'b0;
        s_angle         = '0;
        aresetn         = 1'b0;

        // Zero and the smallest steps either side are exact: one LSB in Q3.28 is
        // four LSBs in Q1.30 and the higher terms vanish.
        probes[0]  = '{32'h0000_0000, 1'b1, 32'h0000_0000};
        probes[1]  = '{32'h0000_0001, 1'b1, 32'h0000_0004};
        probes[2]  = '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFC};
        probes[3]  = '{ANGLE_MAX, 1'b0, 32'h0};
        probes[4]  = '{-ANGLE_MAX, 1'b0, 32'h0};
        probes[5]  = '{32'd421657428, 1'b0, 32'h0};     // pi/2
        probes[6]  = '{-32'd421657428, 1'b0, 32'h0};    // -pi/2
        probes[7]  = '{32'd843314857, 1'b0, 32'h0};     // pi
        probes[8]  = '{32'd1264972285, 1'b0, 32'h0};    // 3pi/2
        probes[9]  = '{32'h4000_0000, 1'b0, 32'h0};     // 4.0
        probes[10] = '{32'hC000_0000, 1'b0, 32'h0};     // -4.0
        // The largest codes either way, where the series drifts away from sine,
        // and a few bit patterns and a small angle.
        probes[11] = '{32'h7FFF_FFFF, 1'b0, 32'h0};
        probes[12] = '{32'h8000_0000, 1'b0, 32'h0};
        probes[13] = '{32'h5555_5555, 1'b0, 32'h0};
        probes[14] = '{32'hAAAA_AAAA, 1'b0, 32'h0};
        probes[15] = '{32'h0010_0000, 1'b0, 32'h0};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (i = 0; i < 16; i++) begin
            send_angle(probes[i].angle,
                       probes[i].known ? probes[i].sine : series_sine(probes[i].angle));
        end

        // Hold off until the pipeline has returned every directed result.
        s_valid = 1'b0;
        while (pending_sines.size() != 0) @(negedge aclk);

        for (i = 0; i < N_RANDOM; i++) begin
            if (i % 64 == 0) gap_chance = 25 * $urandom_range(2, 0);
            if (i == N_RANDOM - N_CALM) pacing_on = 1'b0;
            pick = $urandom_range(99, 0);
            if (pick < 65) begin
                ang = $urandom_range(ANGLE_SPAN, 0);
                ang = ang - ANGLE_MAX;
            end else if (pick < 80) begin
                ang = $urandom;
            end else if (pick < 92) begin
                ang = $urandom_range(32'h0002_0000, 0);
                ang = ang - 32'h0001_0000;
            end else begin
                ang = ANGLE_MAX - $urandom_range(255, 0);
                if ($urandom_range(1, 0) == 1) ang = -ang;
            end
            send_angle(ang, series_sine(ang));
        end

        // Drain, then keep watching for any stray beat before the verdict.
        s_valid = 1'b0;
        while (pending_sines.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sine_mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
src/ts_pkg.sv
src/ts_prep.sv
src/ts_cell.sv
src/ts_out.sv
src/taylor_sine.sv
bench/tb_taylor_sine.sv
